### hw/rtl/adsort_pkg.sv
// Shared types, constants and key helpers for the ascending/descending sorter.
`default_nettype none
package adsort_pkg;

    // Capacity and key width
    localparam int MAX_KEYS  = 32;
    localparam int KEY_WIDTH = 32;
    localparam int CNT_W     = $clog2(MAX_KEYS + 1);

    // Configuration port
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_COMPARE = CFG_IDX_W'(1);

    // Sign bit of a stored key
    localparam logic [KEY_WIDTH-1:0] KEY_SIGN = KEY_WIDTH'(1) << (KEY_WIDTH - 1);

    typedef logic [KEY_WIDTH-1:0] t_key;

    typedef struct packed {
        logic signed [31:0] key_value;
        logic               last_item;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               last_out;
        logic               overflow;
    } t_out_req;

    // What the cells do this cycle
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_SORT,
        OP_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic             odd;
        logic [CNT_W-1:0] count;
        logic             descending;
        logic             signed_cmp;
    } t_cell_ctl;

    // Input pattern to stored key (masked to KEY_WIDTH)
    function automatic t_key to_key(input logic [31:0] raw);
        logic [63:0] w;
        w = 64'(raw);
        return w[KEY_WIDTH-1:0];
    endfunction

    // Stored key to output pattern (zero extended or truncated to 32 bits)
    function automatic logic [31:0] from_key(input t_key k);
        logic [63:0] w;
        w = 64'(k);
        return w[31:0];
    endfunction

    // True when a must come before b in the selected order
    function automatic logic goes_before(input t_key a, input t_key b,
                                         input logic desc, input logic sgn);
        t_key ka;
        t_key kb;
        ka = sgn ? (a ^ KEY_SIGN) : a;
        kb = sgn ? (b ^ KEY_SIGN) : b;
        return desc ? (ka > kb) : (ka < kb);
    endfunction

endpackage
`default_nettype wire

### hw/rtl/ascending_descending_sorter_core.sv
// Top level of the ascending/descending sorter: control plus a row of sorter cells.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | i_in_valid, o_in_stall, i_in_req          | in
//  output  | o_out_valid, i_out_stall, o_out_req       | out
//  config  | i_cfg_valid, o_cfg_ready, i_cfg_index/data| in
//
// Keys load one per cycle into the cell row in arrival order.
// After the last key of a set (n keys stored), n odd-even compare-exchange phases
// run across the cells (none for a single key), then one result per cycle shifts
// out of cell 0 while the output is not stalled. Input is stalled from the last key
// until the final result is in the output register. Synchronous active-low reset
// empties the set and restores descending = 0, signed_compare = 1.
`default_nettype none
module ascending_descending_sorter_core (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wire adsort_pkg::t_in_req          i_in_req,
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output adsort_pkg::t_out_req              o_out_req,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire [adsort_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire                               i_cfg_data
);

    adsort_pkg::t_cell_ctl ctl;
    adsort_pkg::t_key      new_key;
    adsort_pkg::t_key      keys  [adsort_pkg::MAX_KEYS];
    logic                  swaps [adsort_pkg::MAX_KEYS];

    assign o_cfg_ready = 1'b1;
    assign new_key = adsort_pkg::to_key(i_in_req.key_value);

    adsort_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_last_item (i_in_req.last_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_head_key  (keys[0]),
        .o_ctl       (ctl)
    );

    // Row of cells; cell 0 is the head of the sorted run
    for (genvar g = 0; g < adsort_pkg::MAX_KEYS; g++) begin : g_cell
        adsort_pkg::t_key left_key;
        adsort_pkg::t_key right_key;
        logic             left_swap;

        if (g == 0) begin : g_first
            assign left_key  = '0;
            assign left_swap = 1'b0;
        end else begin : g_mid
            assign left_key  = keys[g-1];
            assign left_swap = swaps[g-1];
        end

        if (g == adsort_pkg::MAX_KEYS - 1) begin : g_end
            assign right_key = '0;
        end else begin : g_inner
            assign right_key = keys[g+1];
        end

        adsort_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_index     (adsort_pkg::CNT_W'(g)),
            .i_new_key   (new_key),
            .i_left_key  (left_key),
            .i_left_swap (left_swap),
            .i_right_key (right_key),
            .o_key       (keys[g]),
            .o_swap      (swaps[g])
        );
    end

endmodule
`default_nettype wire

### hw/rtl/adsort_cell.sv
// One sorter cell: holds a key, loads, compare-exchanges with neighbors, shifts left.
`default_nettype none
module adsort_cell (
    input  wire                           i_clk,
    input  wire adsort_pkg::t_cell_ctl    i_ctl,
    input  wire [adsort_pkg::CNT_W-1:0]   i_index,
    input  wire adsort_pkg::t_key         i_new_key,
    input  wire adsort_pkg::t_key         i_left_key,
    input  wire                           i_left_swap,
    input  wire adsort_pkg::t_key         i_right_key,
    output adsort_pkg::t_key              o_key,
    output logic                          o_swap
);

    adsort_pkg::t_key r_key;
    adsort_pkg::t_key n_key;
    logic             lower;
    logic             pair_ok;

    // This cell is the lower one of its pair in the current phase
    assign lower   = (i_index[0] == i_ctl.odd);
    assign pair_ok = ((i_index + adsort_pkg::CNT_W'(1)) < i_ctl.count);

    // Swap decision for the pair this cell leads
    always_comb begin
        o_swap = 1'b0;
        if (i_ctl.op == adsort_pkg::OP_SORT && lower && pair_ok) begin
            o_swap = adsort_pkg::goes_before(i_right_key, r_key,
                                             i_ctl.descending, i_ctl.signed_cmp);
        end
    end

    // Next key
    always_comb begin
        n_key = r_key;
        case (i_ctl.op)
            adsort_pkg::OP_LOAD: begin
                if (i_index == i_ctl.count) begin
                    n_key = i_new_key;
                end
            end
            adsort_pkg::OP_SORT: begin
                if (o_swap) begin
                    n_key = i_right_key;
                end else if (!lower && i_left_swap) begin
                    n_key = i_left_key;
                end
            end
            adsort_pkg::OP_SHIFT: n_key = i_right_key;
            default:              n_key = r_key;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key = r_key;

endmodule
`default_nettype wire

### hw/rtl/adsort_ctrl.sv
// Sequencer: load, sort phases and drain, plus config registers and output register.
`default_nettype none
module adsort_ctrl (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wire                               i_last_item,
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output adsort_pkg::t_out_req              o_out_req,
    input  wire                               i_cfg_valid,
    input  wire [adsort_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire                               i_cfg_data,
    input  wire adsort_pkg::t_key             i_head_key,
    output adsort_pkg::t_cell_ctl             o_ctl
);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_DRAIN
    } t_state;

    localparam logic [adsort_pkg::CNT_W-1:0] CNT_MAX = adsort_pkg::CNT_W'(adsort_pkg::MAX_KEYS);
    localparam logic [adsort_pkg::CNT_W-1:0] CNT_ONE = adsort_pkg::CNT_W'(1);
    localparam logic [adsort_pkg::CNT_W-1:0] CNT_TWO = adsort_pkg::CNT_W'(2);

    t_state                         r_state, n_state;
    logic [adsort_pkg::CNT_W-1:0]   r_count, n_count;
    logic [adsort_pkg::CNT_W-1:0]   r_phase, n_phase;
    logic                           r_odd, n_odd;
    logic                           r_dropped, n_dropped;
    logic                           r_out_valid, n_out_valid;
    adsort_pkg::t_out_req           r_out_req, n_out_req;
    logic                           r_desc, n_desc;
    logic                           r_sgn, n_sgn;
    adsort_pkg::t_cell_op           cell_op;
    logic [adsort_pkg::CNT_W-1:0]   cnt_after;
    logic                           full;
    logic                           take;

    assign full = (r_count >= CNT_MAX);
    assign cnt_after = full ? r_count : (r_count + CNT_ONE);
    assign take = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_phase     = r_phase;
        n_odd       = r_odd;
        n_dropped   = r_dropped;
        n_out_valid = r_out_valid;
        n_out_req   = r_out_req;
        n_desc      = r_desc;
        n_sgn       = r_sgn;
        cell_op     = adsort_pkg::OP_HOLD;

        // Output register empties when taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // Config writes
        if (i_cfg_valid) begin
            case (i_cfg_index)
                adsort_pkg::CFG_DESCENDING:     n_desc = i_cfg_data;
                adsort_pkg::CFG_SIGNED_COMPARE: n_sgn  = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            ST_LOAD: begin
                if (i_in_valid) begin
                    if (full) begin
                        n_dropped = 1'b1;
                    end else begin
                        cell_op = adsort_pkg::OP_LOAD;
                        n_count = cnt_after;
                    end
                    if (i_last_item) begin
                        if (cnt_after >= CNT_TWO) begin
                            n_state = ST_SORT;
                            n_phase = cnt_after;
                            n_odd   = 1'b0;
                        end else begin
                            n_state = ST_DRAIN;
                        end
                    end
                end
            end
            ST_SORT: begin
                cell_op = adsort_pkg::OP_SORT;
                n_odd   = !r_odd;
                n_phase = r_phase - CNT_ONE;
                if (r_phase == CNT_ONE) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (take) begin
                    cell_op     = adsort_pkg::OP_SHIFT;
                    n_out_valid = 1'b1;
                    n_out_req.sorted_value = adsort_pkg::from_key(i_head_key);
                    n_out_req.last_out     = (r_count == CNT_ONE);
                    n_out_req.overflow     = r_dropped;
                    n_count = r_count - CNT_ONE;
                    if (r_count == CNT_ONE) begin
                        n_state   = ST_LOAD;
                        n_dropped = 1'b0;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_phase     <= '0;
            r_odd       <= 1'b0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
            r_desc      <= 1'b0;
            r_sgn       <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_phase     <= n_phase;
            r_odd       <= n_odd;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
            r_desc      <= n_desc;
            r_sgn       <= n_sgn;
        end
        r_out_req <= n_out_req;
    end

    assign o_in_stall  = (r_state != ST_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

    always_comb begin
        o_ctl.op         = cell_op;
        o_ctl.odd        = r_odd;
        o_ctl.count      = r_count;
        o_ctl.descending = r_desc;
        o_ctl.signed_cmp = r_sgn;
    end

endmodule
`default_nettype wire

### tb/adsort_checker.sv
// Checker for the ascending/descending sorter: predicts each sorted run and compares results.
module adsort_checker (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    input  wire                               i_in_stall,
    input  wire adsort_pkg::t_in_req          i_in_req,
    input  wire                               i_out_valid,
    input  wire                               i_out_stall,
    input  wire adsort_pkg::t_out_req         i_out_req,
    input  wire                               i_cfg_valid,
    input  wire                               i_cfg_ready,
    input  wire [adsort_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire                               i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Keys of the set being collected
    adsort_pkg::t_key     set_keys [adsort_pkg::MAX_KEYS];
    int unsigned          set_len     = 0;
    logic                 set_dropped = 1'b0;

    // Shadow copy of the order registers
    logic                 ord_desc    = 1'b0;
    logic                 ord_signed  = 1'b1;

    // Sorted results still owed by the block, oldest first
    adsort_pkg::t_out_req sorted_due [$];
    int                   fails       = 0;

    // True when key a belongs ahead of key b in the current order
    function automatic logic ranks_ahead(input adsort_pkg::t_key a,
                                         input adsort_pkg::t_key b);
        if (ord_signed) begin
            return ord_desc ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
        end
        return ord_desc ? (a > b) : (a < b);
    endfunction

    // Store one key; on the last key of a set, sort it and queue the run
    task automatic load_key(input adsort_pkg::t_in_req req);
        adsort_pkg::t_key     run [adsort_pkg::MAX_KEYS];
        adsort_pkg::t_key     v;
        int                   i;
        int                   j;
        adsort_pkg::t_out_req r;
        if (set_len < adsort_pkg::MAX_KEYS) begin
            set_keys[set_len] = adsort_pkg::t_key'(req.key_value);
            set_len++;
        end else begin
            set_dropped = 1'b1;
        end
        if (!req.last_item) return;
        for (i = 0; i < set_len; i++) run[i] = set_keys[i];
        // insertion sort; equal keys are indistinguishable so stability is moot
        for (i = 1; i < set_len; i++) begin
            v = run[i];
            j = i;
            while (j > 0 && ranks_ahead(v, run[j-1])) begin
                run[j] = run[j-1];
                j--;
            end
            run[j] = v;
        end
        for (i = 0; i < set_len; i++) begin
            r.sorted_value = 32'(run[i]);
            r.last_out     = (i == set_len - 1);
            r.overflow     = set_dropped;
            sorted_due.push_back(r);
        end
        set_len     = 0;
        set_dropped = 1'b0;
    endtask

    // Compare one accepted result against the oldest expectation
    task automatic check_result(input adsort_pkg::t_out_req got);
        adsort_pkg::t_out_req want;
        logic                 bad;
        if (sorted_due.size() == 0) begin
            fails++;
            $display("%0t: unexpected result value=%h last=%b overflow=%b",
                     $time, got.sorted_value, got.last_out, got.overflow);
            return;
        end
        want = sorted_due.pop_front();
        bad  = 1'b0;
        if (got.sorted_value !== want.sorted_value) begin
            bad = 1'b1;
            $display("%0t: sorted_value expected %h actual %h",
                     $time, want.sorted_value, got.sorted_value);
        end
        if (got.last_out !== want.last_out) begin
            bad = 1'b1;
            $display("%0t: last_out expected %b actual %b", $time, want.last_out, got.last_out);
        end
        if (got.overflow !== want.overflow) begin
            bad = 1'b1;
            $display("%0t: overflow expected %b actual %b", $time, want.overflow, got.overflow);
        end
        if (bad) fails++;
    endtask

    // Watch all three channels; results are checked before new keys are loaded
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            set_len     = 0;
            set_dropped = 1'b0;
            ord_desc    = 1'b0;
            ord_signed  = 1'b1;
            sorted_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    adsort_pkg::CFG_DESCENDING:     ord_desc   = i_cfg_data;
                    adsort_pkg::CFG_SIGNED_COMPARE: ord_signed = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) check_result(i_out_req);
            if (i_in_valid && !i_in_stall) load_key(i_in_req);
        end
        o_fail_count <= fails;
        o_pending    <= sorted_due.size();
    end

endmodule

### tb/tb.sv
// Testbench top: clock, reset, key-set stimulus, config writes and the final verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [adsort_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = adsort_pkg::CFG_IDX_W'(2);
    localparam logic [adsort_pkg::CFG_IDX_W-1:0] CFG_IDX_LAST  = '1;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 32;
    localparam int SETTLE       = 8;
    localparam int LIMIT_NS     = 2_000_000;

    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             i_in_valid  = 1'b0;
    logic                             o_in_stall;
    adsort_pkg::t_in_req              i_in_req    = '0;
    logic                             o_out_valid;
    logic                             i_out_stall = 1'b0;
    adsort_pkg::t_out_req             o_out_req;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [adsort_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic                             i_cfg_data  = 1'b0;

    int fail_count;
    int pending;
    int idle_pct  = 0;
    int stall_pct = 0;

    always #2 i_clk = ~i_clk;

    ascending_descending_sorter_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    adsort_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_req     (i_in_req),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_req    (o_out_req),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Random back-pressure on the result side
    always @(posedge i_clk) begin
        i_out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // One key request; valid stays up for the next call, lowered by the caller
    task automatic send_key(input logic [31:0] k, input logic last);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= '{key_value: k, last_item: last};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [adsort_pkg::CFG_IDX_W-1:0] idx, input logic val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // Set both order registers; optionally hit indexes that map to nothing
    task automatic configure(input logic desc, input logic sgn, input logic poke_spare);
        write_reg(adsort_pkg::CFG_DESCENDING, desc);
        write_reg(adsort_pkg::CFG_SIGNED_COMPARE, sgn);
        if (poke_spare) begin
            write_reg(CFG_IDX_SPARE, ~sgn);
            write_reg(CFG_IDX_LAST, ~desc);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every queued result has come out, then let the block settle
    task automatic drain();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Mostly short sets, some long enough to overflow the store
    function automatic int pick_set_len();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 1;
        if (r < 75) return $urandom_range(10, 2);
        if (r < 88) return $urandom_range(adsort_pkg::MAX_KEYS - 1, 11);
        return $urandom_range(adsort_pkg::MAX_KEYS + 8, adsort_pkg::MAX_KEYS);
    endfunction

    // Keys biased toward duplicates and the signed/unsigned boundaries
    function automatic logic [31:0] pick_key(input logic [31:0] prev);
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom;
            4:          return 32'($urandom_range(7));
            5:          return 32'h0 - 32'($urandom_range(8, 1));
            6:          return prev;
            7:          return 32'h8000_0000 + 32'($urandom_range(3));
            8:          return 32'h7fff_ffff - 32'($urandom_range(3));
            default:    return 32'($urandom) | 32'hffff_0000;
        endcase
    endfunction

    initial begin
        logic [31:0] corner_keys [$] = '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                                         32'h0000_0000, 32'h0000_0001, 32'h0000_0005,
                                         32'h0000_0005, 32'h8000_0001, 32'h7fff_fffe};
        int          phase;
        int          mode;
        int          items;
        int          len;
        int          i;
        logic [31:0] k;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed sets under the reset order: single key, corner values, a pair
        send_key(32'h8000_0000, 1'b1);
        for (i = 0; i < corner_keys.size(); i++) begin
            send_key(corner_keys[i], i == corner_keys.size() - 1);
        end
        send_key(32'h0000_0003, 1'b0);
        send_key(32'hffff_fffd, 1'b1);
        i_in_valid <= 1'b0;
        drain();

        // Random sets across every order setting and idling pattern
        k = '0;
        for (phase = 0; phase < PHASES; phase++) begin
            configure(phase[0], ~phase[1], phase == 2 || phase == 5);
            mode = (phase + phase / 4) % 4;
            case (mode)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 76; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 76; end
                default: begin idle_pct = 31; stall_pct = 31; end
            endcase
            items = 0;
            while (items < PHASE_ITEMS) begin
                len = pick_set_len();
                for (i = 0; i < len; i++) begin
                    k = pick_key(k);
                    send_key(k, i == len - 1);
                end
                items += len;
            end
            i_in_valid <= 1'b0;
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(LIMIT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
hw/rtl/adsort_pkg.sv
hw/rtl/adsort_cell.sv
hw/rtl/adsort_ctrl.sv
hw/rtl/ascending_descending_sorter_core.sv
tb/adsort_checker.sv
tb/tb.sv
